@@ hdl/tepe_pkg.sv @@
// package: shared types, protobuf constants and tag helper for the trace event packet encoder
`default_nettype none

package tepe_pkg;

    // one trace event on the input channel
    typedef struct packed {
        logic [63:0] timestamp;
        logic [31:0] sequence_id;
        logic [63:0] track_id;
        logic [1:0]  event_kind;
        logic [63:0] name_id;
        logic        starts_sequence;
    } trace_event_t;

    // one byte of the encoded packet on the result channel
    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } packet_byte_t;

    localparam logic [7:0] VAR_MASK  = 8'h7F;
    localparam logic [7:0] VAR_CONT  = 8'h80;
    localparam int         TAG_SHIFT = 3;

    // wire types
    localparam logic [2:0] WIRE_VARINT = 3'd0;
    localparam logic [2:0] WIRE_LEN    = 3'd2;

    // field numbers
    localparam logic [4:0] FLD_PACKET    = 5'd1;
    localparam logic [4:0] FLD_TIMESTAMP = 5'd8;
    localparam logic [4:0] FLD_SEQ_ID    = 5'd10;
    localparam logic [4:0] FLD_EVENT     = 5'd11;
    localparam logic [4:0] FLD_SEQ_FLAGS = 5'd13;
    localparam logic [4:0] FLD_TYPE      = 5'd9;
    localparam logic [4:0] FLD_TRACK     = 5'd11;
    localparam logic [4:0] FLD_NAME      = 5'd10;

    // sequence flags value sent on a first-of-sequence event
    localparam logic [7:0] SEQ_FLAGS_FIRST = 8'h01;

    // single-byte tag for field numbers below 16
    function automatic logic [7:0] tag_byte(input logic [4:0] number,
                                            input logic [2:0] wire_kind);
        logic [7:0] t;
        t = ({3'b000, number} << TAG_SHIFT) | {5'b00000, wire_kind};
        return t;
    endfunction

endpackage

`default_nettype wire

@@ hdl/tepe_varint_unit.sv @@
// module: shared base-128 varint step, one 7-bit group per use
`default_nettype none

module tepe_varint_unit (
    input  wire logic [63:0] value,
    output logic      [7:0]  group_byte,
    output logic      [63:0] rest,
    output logic             last
);

    always_comb begin
        rest       = value >> 7;
        last       = (rest == 64'd0);
        group_byte = (value[7:0] & tepe_pkg::VAR_MASK) | (last ? 8'h00 : tepe_pkg::VAR_CONT);
    end

endmodule

`default_nettype wire

@@ hdl/tepe_ctrl.sv @@
// module: sequencer that sizes the varints and then walks the packet byte by byte
`default_nettype none

module tepe_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire tepe_pkg::trace_event_t in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output tepe_pkg::packet_byte_t      out_data
);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_MEASURE = 3'b010,
        ST_EMIT    = 3'b100
    } state_t;

    typedef enum logic [3:0] {
        SEG_PKT_TAG   = 4'd0,
        SEG_PKT_LEN   = 4'd1,
        SEG_TS_TAG    = 4'd2,
        SEG_TS        = 4'd3,
        SEG_SEQ_TAG   = 4'd4,
        SEG_SEQ       = 4'd5,
        SEG_FLAG_TAG  = 4'd6,
        SEG_FLAG_VAL  = 4'd7,
        SEG_EV_TAG    = 4'd8,
        SEG_EV_LEN    = 4'd9,
        SEG_TYPE_TAG  = 4'd10,
        SEG_TYPE      = 4'd11,
        SEG_TRACK_TAG = 4'd12,
        SEG_TRACK     = 4'd13,
        SEG_NAME_TAG  = 4'd14,
        SEG_NAME      = 4'd15
    } seg_t;

    localparam logic [1:0] IDX_TS    = 2'd0;
    localparam logic [1:0] IDX_SEQ   = 2'd1;
    localparam logic [1:0] IDX_TRACK = 2'd2;
    localparam logic [1:0] IDX_NAME  = 2'd3;

    state_t state_reg, state_next;
    seg_t   seg_reg, seg_next;
    logic [1:0]  idx_reg, idx_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  len_reg [4];
    logic [63:0] work_reg, work_next;
    tepe_pkg::trace_event_t ev_reg;
    logic        name_nz_reg;

    logic [7:0]  unit_byte;
    logic [63:0] unit_rest;
    logic        unit_last;

    tepe_varint_unit u_varint (
        .value      (work_reg),
        .group_byte (unit_byte),
        .rest       (unit_rest),
        .last       (unit_last)
    );

    logic [4:0]  ev_len;
    logic [5:0]  pkt_len;
    logic        seg_done;
    logic        is_last;
    logic [7:0]  byte_val;
    logic [63:0] meas_load;
    logic [63:0] seg_load;
    logic        xfer;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign xfer      = out_valid && out_ready;

    // message lengths from the measured varint sizes
    always_comb begin
        ev_len  = 5'd3 + {1'b0, len_reg[IDX_TRACK]}
                + (name_nz_reg ? (5'd1 + {1'b0, len_reg[IDX_NAME]}) : 5'd0);
        pkt_len = 6'd4 + {2'b00, len_reg[IDX_TS]} + {2'b00, len_reg[IDX_SEQ]}
                + (ev_reg.starts_sequence ? 6'd2 : 6'd0) + {1'b0, ev_len};
    end

    // next value to measure
    always_comb begin
        unique case (idx_reg)
            IDX_TS:    meas_load = {32'd0, ev_reg.sequence_id};
            IDX_SEQ:   meas_load = ev_reg.track_id;
            IDX_TRACK: meas_load = ev_reg.name_id;
            IDX_NAME:  meas_load = ev_reg.timestamp;
            default:   meas_load = ev_reg.timestamp;
        endcase
    end

    // byte of the current segment and where to go after it
    always_comb begin
        byte_val = 8'h00;
        seg_done = 1'b1;
        seg_next = seg_reg;
        unique case (seg_reg)
            SEG_PKT_TAG: begin
                byte_val = tepe_pkg::tag_byte(tepe_pkg::FLD_PACKET, tepe_pkg::WIRE_LEN);
                seg_next = SEG_PKT_LEN;
            end
            SEG_PKT_LEN: begin
                byte_val = {2'b00, pkt_len};
                seg_next = SEG_TS_TAG;
            end
            SEG_TS_TAG: begin
                byte_val = tepe_pkg::tag_byte(tepe_pkg::FLD_TIMESTAMP, tepe_pkg::WIRE_VARINT);
                seg_next = SEG_TS;
            end
            SEG_TS: begin
                byte_val = unit_byte;
                seg_done = unit_last;
                seg_next = SEG_SEQ_TAG;
            end
            SEG_SEQ_TAG: begin
                byte_val = tepe_pkg::tag_byte(tepe_pkg::FLD_SEQ_ID, tepe_pkg::WIRE_VARINT);
                seg_next = SEG_SEQ;
            end
            SEG_SEQ: begin
                byte_val = unit_byte;
                seg_done = unit_last;
                seg_next = ev_reg.starts_sequence ? SEG_FLAG_TAG : SEG_EV_TAG;
            end
            SEG_FLAG_TAG: begin
                byte_val = tepe_pkg::tag_byte(tepe_pkg::FLD_SEQ_FLAGS, tepe_pkg::WIRE_VARINT);
                seg_next = SEG_FLAG_VAL;
            end
            SEG_FLAG_VAL: begin
                byte_val = tepe_pkg::SEQ_FLAGS_FIRST;
                seg_next = SEG_EV_TAG;
            end
            SEG_EV_TAG: begin
                byte_val = tepe_pkg::tag_byte(tepe_pkg::FLD_EVENT, tepe_pkg::WIRE_LEN);
                seg_next = SEG_EV_LEN;
            end
            SEG_EV_LEN: begin
                byte_val = {3'b000, ev_len};
                seg_next = SEG_TYPE_TAG;
            end
            SEG_TYPE_TAG: begin
                byte_val = tepe_pkg::tag_byte(tepe_pkg::FLD_TYPE, tepe_pkg::WIRE_VARINT);
                seg_next = SEG_TYPE;
            end
            SEG_TYPE: begin
                byte_val = {6'b000000, ev_reg.event_kind};
                seg_next = SEG_TRACK_TAG;
            end
            SEG_TRACK_TAG: begin
                byte_val = tepe_pkg::tag_byte(tepe_pkg::FLD_TRACK, tepe_pkg::WIRE_VARINT);
                seg_next = SEG_TRACK;
            end
            SEG_TRACK: begin
                byte_val = unit_byte;
                seg_done = unit_last;
                seg_next = SEG_NAME_TAG;
            end
            SEG_NAME_TAG: begin
                byte_val = tepe_pkg::tag_byte(tepe_pkg::FLD_NAME, tepe_pkg::WIRE_VARINT);
                seg_next = SEG_NAME;
            end
            SEG_NAME: begin
                byte_val = unit_byte;
                seg_done = unit_last;
                seg_next = SEG_PKT_TAG;
            end
            default: begin
                byte_val = 8'h00;
            end
        endcase
        // name field left out when the id is zero
        is_last = seg_done && ((seg_reg == SEG_NAME) || ((seg_reg == SEG_TRACK) && !name_nz_reg));
    end

    // value to load into the shared unit when a segment starts
    always_comb begin
        unique case (seg_next)
            SEG_TS:    seg_load = ev_reg.timestamp;
            SEG_SEQ:   seg_load = {32'd0, ev_reg.sequence_id};
            SEG_TRACK: seg_load = ev_reg.track_id;
            SEG_NAME:  seg_load = ev_reg.name_id;
            default:   seg_load = unit_rest;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        work_next  = work_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_MEASURE;
                    idx_next   = IDX_TS;
                    cnt_next   = 4'd0;
                    work_next  = in_data.timestamp;
                end
            end
            ST_MEASURE: begin
                if (unit_last) begin
                    cnt_next  = 4'd0;
                    idx_next  = idx_reg + 2'd1;
                    work_next = meas_load;
                    if (idx_reg == IDX_NAME) begin
                        state_next = ST_EMIT;
                    end
                end else begin
                    cnt_next  = cnt_reg + 4'd1;
                    work_next = unit_rest;
                end
            end
            ST_EMIT: begin
                if (xfer) begin
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else if (seg_done) begin
                        work_next = seg_load;
                    end else begin
                        work_next = unit_rest;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_data.packet_byte = byte_val;
    assign out_data.last_byte   = is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seg_reg   <= SEG_PKT_TAG;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_MEASURE) begin
                seg_reg <= SEG_PKT_TAG;
            end else if (xfer && seg_done) begin
                seg_reg <= seg_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        work_reg <= work_next;
        if (in_valid && in_ready) begin
            ev_reg      <= in_data;
            name_nz_reg <= (in_data.name_id != 64'd0);
        end
        if ((state_reg == ST_MEASURE) && unit_last) begin
            len_reg[idx_reg] <= cnt_reg + 4'd1;
        end
    end

endmodule

`default_nettype wire

@@ hdl/trace_event_packet_encoder.sv @@
// module: top level of the trace event packet encoder with its output register
`default_nettype none

// Encodes one trace event per input transfer into one length-delimited protobuf
// trace packet, sent out one byte per output transfer with last_byte set on the
// final byte. A packet is 12 to 47 bytes. The block works on one event at a time:
// s_ready is high only while it is idle. An event is taken while idle, then the
// varint bytes of timestamp, sequence_id, track_id and name_id are counted in the
// shared varint unit to size the two length prefixes, then the packet is sent
// byte by byte, held by any output stall, as the same unit turns out the bytes.
// An output register lets the last byte wait on m_ready while the next event is
// already taken in.

module trace_event_packet_encoder (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // event input channel
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire tepe_pkg::trace_event_t s_data,
    // packet byte output channel
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output tepe_pkg::packet_byte_t      m_data
);

    logic                   byte_valid;
    logic                   byte_ready;
    tepe_pkg::packet_byte_t byte_data;

    logic                   m_valid_reg;
    tepe_pkg::packet_byte_t m_data_reg;

    // sequencer and shared varint unit
    tepe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (byte_valid),
        .out_ready (byte_ready),
        .out_data  (byte_data)
    );

    // output register takes a new byte when empty or being drained
    assign byte_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (byte_ready) begin
            m_valid_reg <= byte_valid;
        end
    end

    // payload holds while a transfer is stalled
    always_ff @(posedge aclk) begin
        if (byte_ready && byte_valid) begin
            m_data_reg <= byte_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ tb/packet_byte_checker.sv @@
// checker: predicts the encoded packet bytes of each accepted event and compares the byte stream
module packet_byte_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  tepe_pkg::trace_event_t           s_data,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  tepe_pkg::packet_byte_t           m_data,
    output int                               mismatch_count,
    output int                               pending_bytes
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PACKET_MAX = 47;
    localparam int REPORT_MAX = 10;

    typedef logic [7:0] octets_t[$];

    tepe_pkg::packet_byte_t expected_bytes[$];

    // base-128, low group first, continuation bit on all but the last byte
    function automatic octets_t varint_octets(input logic [63:0] v);
        octets_t    q;
        logic [63:0] rest;
        logic [7:0] b;
        rest = v;
        do begin
            b = rest[7:0] & tepe_pkg::VAR_MASK;
            rest = rest >> 7;
            if (rest != 64'd0) begin
                b = b | tepe_pkg::VAR_CONT;
            end
            q.push_back(b);
        end while (rest != 64'd0);
        return q;
    endfunction

    function automatic logic [7:0] field_tag(input logic [4:0] number, input logic [2:0] wire_kind);
        return (8'(number) << tepe_pkg::TAG_SHIFT) | 8'(wire_kind);
    endfunction

    function automatic octets_t uint_field(input logic [4:0] number, input logic [63:0] v);
        octets_t q;
        q.push_back(field_tag(number, tepe_pkg::WIRE_VARINT));
        q = {q, varint_octets(v)};
        return q;
    endfunction

    function automatic octets_t nested_field(input logic [4:0] number, input octets_t payload);
        octets_t q;
        q.push_back(field_tag(number, tepe_pkg::WIRE_LEN));
        q = {q, varint_octets(64'(payload.size())), payload};
        return q;
    endfunction

    function automatic octets_t encode_trace_packet(input tepe_pkg::trace_event_t ev);
        octets_t msg;
        octets_t body;
        octets_t pkt;
        msg = {uint_field(tepe_pkg::FLD_TYPE, 64'(ev.event_kind)),
               uint_field(tepe_pkg::FLD_TRACK, ev.track_id)};
        // a zero name id leaves the name field out
        if (ev.name_id != 64'd0) begin
            msg = {msg, uint_field(tepe_pkg::FLD_NAME, ev.name_id)};
        end
        body = {uint_field(tepe_pkg::FLD_TIMESTAMP, ev.timestamp),
                uint_field(tepe_pkg::FLD_SEQ_ID, 64'(ev.sequence_id))};
        if (ev.starts_sequence) begin
            body = {body, uint_field(tepe_pkg::FLD_SEQ_FLAGS, 64'(tepe_pkg::SEQ_FLAGS_FIRST))};
        end
        body = {body, nested_field(tepe_pkg::FLD_EVENT, msg)};
        pkt = nested_field(tepe_pkg::FLD_PACKET, body);
        while (pkt.size() > PACKET_MAX) begin
            pkt.pop_back();
        end
        return pkt;
    endfunction

    always @(posedge aclk) begin
        octets_t                pkt;
        tepe_pkg::packet_byte_t want;
        if (!aresetn) begin
            mismatch_count = 0;
            expected_bytes.delete();
        end else begin
            if (s_valid && s_ready) begin
                pkt = encode_trace_packet(s_data);
                foreach (pkt[i]) begin
                    expected_bytes.push_back('{packet_byte: pkt[i],
                                               last_byte: (i == pkt.size() - 1)});
                end
            end
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    if (mismatch_count < REPORT_MAX) begin
                        $display("%0t: unexpected byte %02h last %0b", $realtime,
                                 m_data.packet_byte, m_data.last_byte);
                    end
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_data.packet_byte !== want.packet_byte ||
                        m_data.last_byte !== want.last_byte) begin
                        if (mismatch_count < REPORT_MAX) begin
                            $display("%0t: byte exp %02h got %02h, last exp %0b got %0b",
                                     $realtime, want.packet_byte, m_data.packet_byte,
                                     want.last_byte, m_data.last_byte);
                        end
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
        end
        pending_bytes = expected_bytes.size();
    end

endmodule

@@ tb/tb.sv @@
// testbench top: event stimulus, byte sink with stalls, watchdog and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_EVENTS = 180;
    localparam int IDLE_LIMIT    = 3000;   // cycles with no transfer on either channel
    localparam int DRAIN_CYCLES  = 120;    // covers the longest event latency
    localparam int HOLD_CYCLES   = 300;    // the long receiver hold-off
    localparam int HOLD_AT_BYTE  = 400;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    tepe_pkg::trace_event_t s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    tepe_pkg::packet_byte_t m_data;

    int mismatch_count;
    int pending_bytes;
    int idle_cycles = 0;
    int events_sent = 0;
    int bytes_taken = 0;

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    trace_event_packet_encoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    packet_byte_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .pending_bytes  (pending_bytes)
    );

    // random value whose varint length is spread over 1 to 10 bytes
    function automatic logic [63:0] spread_value();
        logic [63:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) begin
            return r;   // full width, so every bit sees both values
        end
        return r >> $urandom_range(0, 63);
    endfunction

    function automatic tepe_pkg::trace_event_t random_event();
        tepe_pkg::trace_event_t ev;
        ev.timestamp       = spread_value();
        ev.sequence_id     = 32'(spread_value());
        ev.track_id        = spread_value();
        // kind zero is rare but still encoded as given
        ev.event_kind      = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
        ev.name_id         = ($urandom_range(0, 4) == 0) ? 64'd0 : spread_value();
        ev.starts_sequence = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    // one event transfer; the gap before it is random except in burst stretches
    task automatic send_event(input logic [63:0] ts, input logic [31:0] seq,
                              input logic [63:0] track, input logic [1:0] kind,
                              input logic [63:0] name, input logic first);
        int gap;
        gap = ((events_sent / 16) % 3 == 1) ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{timestamp: ts, sequence_id: seq, track_id: track, event_kind: kind,
                     name_id: name, starts_sequence: first};
        do @(posedge aclk); while (!s_ready);
        events_sent = events_sent + 1;
    endtask

    // byte sink: random stall per byte, burst stretches, and one long hold-off
    // so the output register fills and the encoder stops taking events
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (bytes_taken == HOLD_AT_BYTE) begin
                gap = HOLD_CYCLES;
            end else if ((bytes_taken / 64) % 3 == 1) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 8);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            bytes_taken = bytes_taken + 1;
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("trace_event_packet_encoder: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        tepe_pkg::trace_event_t ev;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: smallest packet, kind zero, no name, no flags
        send_event(64'd0, 32'd0, 64'd0, 2'd0, 64'd0, 1'b0);
        // largest packet: every varint at full length, flags and name present
        send_event('1, '1, '1, 2'd3, '1, 1'b1);
        // event kinds one to three, with and without name and flags
        send_event(64'd1, 32'd1, 64'd1, 2'd1, 64'd1, 1'b1);
        send_event(64'd2, 32'd2, 64'd2, 2'd2, 64'd0, 1'b0);
        send_event(64'd3, 32'd3, 64'd3, 2'd3, 64'd5, 1'b0);
        send_event(64'd4, 32'd4, 64'd4, 2'd1, 64'd0, 1'b1);
        // varint group boundaries
        send_event(64'd127, 32'd128, 64'd16383, 2'd2, 64'd16384, 1'b0);
        send_event(64'd128, 32'h0FFF_FFFF, 64'h1000_0000, 2'd3, 64'd127, 1'b1);
        send_event(64'h00FF_FFFF_FFFF_FFFF, 32'h1000_0000, 64'h0100_0000_0000_0000,
                   2'd1, 64'h8000_0000_0000_0000, 1'b0);
        send_event(64'h8000_0000_0000_0000, 32'h8000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                   2'd2, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_event(64'h0000_0007_FFFF_FFFF, 32'hFFFF_FFFF, 64'h0000_0008_0000_0000,
                   2'd0, 64'd1, 1'b1);
        // alternating bit patterns
        send_event(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 64'h5555_5555_5555_5555,
                   2'd3, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_event(64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA,
                   2'd1, 64'h5555_5555_5555_5555, 1'b1);

        // random part
        repeat (RANDOM_EVENTS) begin
            ev = random_event();
            send_event(ev.timestamp, ev.sequence_id, ev.track_id, ev.event_kind,
                       ev.name_id, ev.starts_sequence);
        end
        s_valid <= 1'b0;

        // drain, then let any stray byte show up
        while (pending_bytes != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_bytes == 0) begin
            $display("trace_event_packet_encoder: match");
        end else begin
            $display("trace_event_packet_encoder: mismatch");
        end
        $finish;
    end

endmodule
